### sv/npd_pkg.sv
// ----------------------------------------------------------------------------
// npd_pkg: shared types and constants for the H.264 new picture detector
// Slice header record, stored slice context, result record and code values.
// ----------------------------------------------------------------------------
`default_nettype none

package npd_pkg;

  localparam int unsigned PpsIdW    = 8;
  localparam int unsigned FrameNumW = 16;
  localparam int unsigned IdrIdW    = 16;
  localparam int unsigned PocLsbW   = 16;
  localparam int unsigned DeltaW    = 32;
  localparam int unsigned KindW     = 3;
  localparam int unsigned FtypeW    = 2;
  localparam int unsigned PstructW  = 2;
  localparam int unsigned PocTypeW  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;

  // Stream packing
  localparam int unsigned InTdataW  = 160;
  localparam int unsigned InTuserW  = 4;
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned OutTuserW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPocType     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDeltaZero   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBotPocPres  = 2'd2;

  // poc type values that select compared fields
  localparam logic [PocTypeW-1:0] PocType0 = 2'd0;
  localparam logic [PocTypeW-1:0] PocType1 = 2'd1;

  // slice kind: slice type code mod 5
  localparam logic [KindW-1:0] SliceP  = 3'd0;
  localparam logic [KindW-1:0] SliceB  = 3'd1;
  localparam logic [KindW-1:0] SliceI  = 3'd2;
  localparam logic [KindW-1:0] SliceSp = 3'd3;
  localparam logic [KindW-1:0] SliceSi = 3'd4;

  // frame type codes
  localparam logic [FtypeW-1:0] FtypeIdr = 2'd0;
  localparam logic [FtypeW-1:0] FtypeI   = 2'd1;
  localparam logic [FtypeW-1:0] FtypeP   = 2'd2;
  localparam logic [FtypeW-1:0] FtypeB   = 2'd3;

  // picture structure codes
  localparam logic [PstructW-1:0] PstructFrame  = 2'd0;
  localparam logic [PstructW-1:0] PstructTop    = 2'd1;
  localparam logic [PstructW-1:0] PstructBottom = 2'd2;

  typedef struct packed {
    logic [PpsIdW-1:0]    pps_id;
    logic [FrameNumW-1:0] frame_number;
    logic                 field_pic;
    logic                 bottom_flag;
    logic                 is_idr;
    logic [IdrIdW-1:0]    idr_id;
    logic [PocLsbW-1:0]   poc_lsb;
    logic [DeltaW-1:0]    delta_poc_bottom;
    logic [DeltaW-1:0]    delta_poc_first;
    logic [DeltaW-1:0]    delta_poc_second;
    logic [KindW-1:0]     slice_kind;
  } slice_t;

  typedef struct packed {
    logic   valid;
    slice_t hdr;
  } prev_t;

  typedef struct packed {
    logic [PocTypeW-1:0] poc_type;
    logic                delta_poc_always_zero;
    logic                bottom_poc_present;
  } cfg_t;

  typedef struct packed {
    logic                new_picture;
    logic [FtypeW-1:0]   frame_type;
    logic [PstructW-1:0] picture_structure;
  } result_t;

endpackage

`default_nettype wire

### sv/h264_new_picture_detector.sv
// ----------------------------------------------------------------------------
// h264_new_picture_detector: first-slice-of-new-picture detection
// Compares each parsed slice header with the previous one and reports
// new_picture, frame type and picture structure.
// ----------------------------------------------------------------------------
// One transaction per clock in steady state, while the result side is not
// stalled. A slice header is captured in an input register, compared against
// the stored previous slice in a single combinational pass and written to
// the result register. The previous-slice context is updated in the same
// cycle the header moves into the result register, so a header directly
// following another is compared against it. The input stays ready as long
// as the result register is empty or being drained. The comparison follows
// the reduced H.264 first-VCL-NAL rule: pps id, frame number, field and IDR
// flags always; bottom flag when both slices are fields; IDR picture id when
// both are IDR; poc lsb / delta fields as selected by poc_type,
// delta_poc_always_zero and bottom_poc_present. Delta fields that the
// registers mark absent are stored as zero. The configuration registers may
// be written only while no header is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_new_picture_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // slice header input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, lsb up: pps_id[7:0], frame_number[23:8], field_pic[24],
  // bottom_flag[25], idr_id[41:26], poc_lsb[57:42],
  // delta_poc_bottom[89:58], delta_poc_first[121:90],
  // delta_poc_second[153:122], zero pad[159:154]
  input  logic [npd_pkg::InTdataW-1:0]    s_axis_tdata,
  // tuser, lsb up: is_idr[0], slice_kind[3:1]
  input  logic [npd_pkg::InTuserW-1:0]    s_axis_tuser,

  // result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, lsb up: new_picture[0], zero pad[7:1]
  output logic [npd_pkg::OutTdataW-1:0]   m_axis_tdata,
  // tuser, lsb up: frame_type[1:0], picture_structure[3:2]
  output logic [npd_pkg::OutTuserW-1:0]   m_axis_tuser,

  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [npd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [npd_pkg::CfgDataW-1:0]    cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  npd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        npd_pkg::RegPocType:    cfg_q.poc_type              <= cfg_data_i;
        npd_pkg::RegDeltaZero:  cfg_q.delta_poc_always_zero <= cfg_data_i[0];
        npd_pkg::RegBotPocPres: cfg_q.bottom_poc_present    <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpack and input register
  // --------------------------------------------------------------------------
  npd_pkg::slice_t in_hdr;

  assign in_hdr.pps_id           = s_axis_tdata[7:0];
  assign in_hdr.frame_number     = s_axis_tdata[23:8];
  assign in_hdr.field_pic        = s_axis_tdata[24];
  assign in_hdr.bottom_flag      = s_axis_tdata[25];
  assign in_hdr.idr_id           = s_axis_tdata[41:26];
  assign in_hdr.poc_lsb          = s_axis_tdata[57:42];
  assign in_hdr.delta_poc_bottom = s_axis_tdata[89:58];
  assign in_hdr.delta_poc_first  = s_axis_tdata[121:90];
  assign in_hdr.delta_poc_second = s_axis_tdata[153:122];
  assign in_hdr.is_idr           = s_axis_tuser[0];
  assign in_hdr.slice_kind       = s_axis_tuser[3:1];

  logic            in_vld_q;
  npd_pkg::slice_t in_hdr_q;
  logic            adv;      // header moves from input to result register
  logic            in_acc;

  assign adv           = in_vld_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_hdr_q <= in_hdr;
    end
  end

  // --------------------------------------------------------------------------
  // Compare against the previous slice; context updates on advance
  // --------------------------------------------------------------------------
  npd_pkg::prev_t   prev;
  npd_pkg::slice_t  norm_hdr;
  npd_pkg::result_t res;

  npd_compare u_compare (
    .cur_i  (in_hdr_q),
    .prev_i (prev),
    .cfg_i  (cfg_q),
    .norm_o (norm_hdr),
    .res_o  (res)
  );

  npd_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv),
    .hdr_i  (norm_hdr),
    .prev_o (prev)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic             out_vld_q;
  npd_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (~out_vld_q | m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(npd_pkg::OutTdataW-1){1'b0}}, res_q.new_picture};
  assign m_axis_tuser  = {res_q.picture_structure, res_q.frame_type};

endmodule

`default_nettype wire

### sv/npd_compare.sv
// ----------------------------------------------------------------------------
// npd_compare: slice header comparison
// Normalizes absent fields, compares against the stored previous slice and
// classifies frame type and picture structure. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module npd_compare (
  input  npd_pkg::slice_t  cur_i,
  input  npd_pkg::prev_t   prev_i,
  input  npd_pkg::cfg_t    cfg_i,
  output npd_pkg::slice_t  norm_o,
  output npd_pkg::result_t res_o
);

  logic bot;
  logic bot_delta;
  logic keep_dbot;
  logic keep_d0;
  logic keep_d1;
  logic diff;
  npd_pkg::slice_t n;

  assign bot       = cur_i.field_pic & cur_i.bottom_flag;
  assign bot_delta = cfg_i.bottom_poc_present & ~cur_i.field_pic;
  assign keep_dbot = (cfg_i.poc_type == npd_pkg::PocType0) & bot_delta;
  assign keep_d0   = (cfg_i.poc_type == npd_pkg::PocType1) & ~cfg_i.delta_poc_always_zero;
  assign keep_d1   = keep_d0 & bot_delta;

  always_comb begin
    n                  = cur_i;
    n.bottom_flag      = bot;
    n.delta_poc_bottom = keep_dbot ? cur_i.delta_poc_bottom : '0;
    n.delta_poc_first  = keep_d0 ? cur_i.delta_poc_first : '0;
    n.delta_poc_second = keep_d1 ? cur_i.delta_poc_second : '0;
  end

  assign norm_o = n;

  always_comb begin
    diff = (prev_i.hdr.pps_id != n.pps_id)
         | (prev_i.hdr.frame_number != n.frame_number)
         | (prev_i.hdr.field_pic != n.field_pic)
         | (prev_i.hdr.is_idr != n.is_idr);
    if (n.field_pic && prev_i.hdr.field_pic) begin
      diff = diff | (prev_i.hdr.bottom_flag != n.bottom_flag);
    end
    if (n.is_idr && prev_i.hdr.is_idr) begin
      diff = diff | (prev_i.hdr.idr_id != n.idr_id);
    end
    if (cfg_i.poc_type == npd_pkg::PocType0) begin
      diff = diff | (prev_i.hdr.poc_lsb != n.poc_lsb);
    end
    if (keep_dbot) begin
      diff = diff | (prev_i.hdr.delta_poc_bottom != n.delta_poc_bottom);
    end
    if (keep_d0) begin
      diff = diff | (prev_i.hdr.delta_poc_first != n.delta_poc_first);
    end
    if (keep_d1) begin
      diff = diff | (prev_i.hdr.delta_poc_second != n.delta_poc_second);
    end
  end

  always_comb begin
    res_o.new_picture = ~prev_i.valid | diff;

    if (n.is_idr) begin
      res_o.frame_type = npd_pkg::FtypeIdr;
    end else begin
      case (n.slice_kind) inside
        npd_pkg::SliceI, npd_pkg::SliceSi: res_o.frame_type = npd_pkg::FtypeI;
        npd_pkg::SliceB:                   res_o.frame_type = npd_pkg::FtypeB;
        default:                           res_o.frame_type = npd_pkg::FtypeP;
      endcase
    end

    if (!n.field_pic) begin
      res_o.picture_structure = npd_pkg::PstructFrame;
    end else if (bot) begin
      res_o.picture_structure = npd_pkg::PstructBottom;
    end else begin
      res_o.picture_structure = npd_pkg::PstructTop;
    end
  end

endmodule

`default_nettype wire

### sv/npd_state.sv
// ----------------------------------------------------------------------------
// npd_state: previous slice context
// Holds the normalized fields of the last processed slice header.
// ----------------------------------------------------------------------------
`default_nettype none

module npd_state (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  npd_pkg::slice_t hdr_i,
  output npd_pkg::prev_t  prev_o
);

  logic            valid_q;
  npd_pkg::slice_t hdr_q;

  // only the valid flag needs reset; stored fields are ignored until valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      hdr_q <= hdr_i;
    end
  end

  assign prev_o.valid = valid_q;
  assign prev_o.hdr   = hdr_q;

endmodule

`default_nettype wire

### sv/npd_checker.sv
// ----------------------------------------------------------------------------
// npd_checker: port-level checks for the new picture detector
// Throughput, stall and encoding checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module npd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [npd_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic [npd_pkg::OutTuserW-1:0] m_axis_tuser,
  input  logic                          cfg_ready_o
);

  // input never blocks while the result side can take data
  a_in_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while result side free");

  // picture structure has no code for value three
  a_pstruct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[3:2] != 2'd3))
    else $error("invalid picture structure");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // configuration port never back-pressures
  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind h264_new_picture_detector npd_checker u_npd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

### tb/sv/npd_result_checker.sv
// ----------------------------------------------------------------------------
// npd_result_checker: slice header scoreboard for the new picture detector
// Tracks register writes and accepted slice headers, predicts the result of
// each header, and checks every result transaction against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module npd_result_checker
  import npd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 hdr_valid_i,
  input  logic                 hdr_ready_i,
  input  logic [InTdataW-1:0]  hdr_tdata_i,
  input  logic [InTuserW-1:0]  hdr_tuser_i,

  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OutTdataW-1:0] res_tdata_i,
  input  logic [OutTuserW-1:0] res_tuser_i,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,

  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   new_pics_o
);

  cfg_t    active_cfg;
  logic    have_prev;
  slice_t  prev_slice;
  result_t picture_results[$];

  slice_t  hdr;
  result_t want;
  result_t got;
  int      err_count;
  int      checked_count;
  int      new_pic_count;

  // Compares a header with the stored previous slice and stores it.
  function automatic result_t predict_picture(input slice_t s);
    slice_t  cur;
    result_t r;
    logic    bot_delta;
    logic    delta_cmp;
    logic    newp;

    cur = s;
    cur.bottom_flag = s.field_pic & s.bottom_flag;
    bot_delta = active_cfg.bottom_poc_present && !s.field_pic;
    delta_cmp = (active_cfg.poc_type == PocType1) && !active_cfg.delta_poc_always_zero;

    // fields absent under the current registers are held as zero
    if (!((active_cfg.poc_type == PocType0) && bot_delta)) cur.delta_poc_bottom = '0;
    if (!delta_cmp) begin
      cur.delta_poc_first  = '0;
      cur.delta_poc_second = '0;
    end else if (!bot_delta) begin
      cur.delta_poc_second = '0;
    end

    newp = !have_prev;
    if (have_prev) begin
      newp |= prev_slice.pps_id != cur.pps_id;
      newp |= prev_slice.frame_number != cur.frame_number;
      newp |= prev_slice.field_pic != cur.field_pic;
      if (cur.field_pic && prev_slice.field_pic)
        newp |= prev_slice.bottom_flag != cur.bottom_flag;
      newp |= prev_slice.is_idr != cur.is_idr;
      if (cur.is_idr && prev_slice.is_idr) newp |= prev_slice.idr_id != cur.idr_id;
      if (active_cfg.poc_type == PocType0) begin
        newp |= prev_slice.poc_lsb != cur.poc_lsb;
        if (bot_delta) newp |= prev_slice.delta_poc_bottom != cur.delta_poc_bottom;
      end
      if (delta_cmp) begin
        newp |= prev_slice.delta_poc_first != cur.delta_poc_first;
        if (bot_delta) newp |= prev_slice.delta_poc_second != cur.delta_poc_second;
      end
    end

    r.new_picture = newp;
    if (cur.is_idr) r.frame_type = FtypeIdr;
    else if (cur.slice_kind == SliceI || cur.slice_kind == SliceSi) r.frame_type = FtypeI;
    else if (cur.slice_kind == SliceB) r.frame_type = FtypeB;
    else r.frame_type = FtypeP;  // P, SP and the unused kinds
    if (!cur.field_pic) r.picture_structure = PstructFrame;
    else if (cur.bottom_flag) r.picture_structure = PstructBottom;
    else r.picture_structure = PstructTop;

    have_prev  = 1'b1;
    prev_slice = cur;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cfg    = '0;
      have_prev     = 1'b0;
      prev_slice    = '0;
      err_count     = 0;
      checked_count = 0;
      new_pic_count = 0;
      picture_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPocType:    active_cfg.poc_type = cfg_data_i;
          RegDeltaZero:  active_cfg.delta_poc_always_zero = cfg_data_i[0];
          RegBotPocPres: active_cfg.bottom_poc_present = cfg_data_i[0];
          default: ;
        endcase
      end

      // results first, so a header accepted on the same edge is never matched
      if (res_valid_i && res_ready_i) begin
        got.new_picture       = res_tdata_i[0];
        got.frame_type        = res_tuser_i[1:0];
        got.picture_structure = res_tuser_i[3:2];
        if (picture_results.size() == 0) begin
          $error("result transaction with no slice header pending");
          err_count++;
        end else begin
          want = picture_results.pop_front();
          checked_count++;
          if (got.new_picture) new_pic_count++;
          if (got.new_picture !== want.new_picture) begin
            $error("new_picture: expected %0d, got %0d", want.new_picture, got.new_picture);
            err_count++;
          end
          if (got.frame_type !== want.frame_type) begin
            $error("frame_type: expected %0d, got %0d", want.frame_type, got.frame_type);
            err_count++;
          end
          if (got.picture_structure !== want.picture_structure) begin
            $error("picture_structure: expected %0d, got %0d",
                   want.picture_structure, got.picture_structure);
            err_count++;
          end
        end
      end

      if (hdr_valid_i && hdr_ready_i) begin
        hdr.pps_id           = hdr_tdata_i[7:0];
        hdr.frame_number     = hdr_tdata_i[23:8];
        hdr.field_pic        = hdr_tdata_i[24];
        hdr.bottom_flag      = hdr_tdata_i[25];
        hdr.idr_id           = hdr_tdata_i[41:26];
        hdr.poc_lsb          = hdr_tdata_i[57:42];
        hdr.delta_poc_bottom = hdr_tdata_i[89:58];
        hdr.delta_poc_first  = hdr_tdata_i[121:90];
        hdr.delta_poc_second = hdr_tdata_i[153:122];
        hdr.is_idr           = hdr_tuser_i[0];
        hdr.slice_kind       = hdr_tuser_i[3:1];
        picture_results.insert(picture_results.size(), predict_picture(hdr));
      end
    end
    errors_o   <= err_count;
    pending_o  <= picture_results.size();
    checked_o  <= checked_count;
    new_pics_o <= new_pic_count;
  end

endmodule

### tb/sv/h264_new_picture_detector_tb.sv
// ----------------------------------------------------------------------------
// h264_new_picture_detector_tb: testbench top for the new picture detector
// Drives slice headers and register writes, throttles the result stream and
// reports the verdict; prediction and checking live in npd_result_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module h264_new_picture_detector_tb;
  import npd_pkg::*;

  localparam int ClkPeriod      = 8;
  localparam int ResetCycles    = 11;
  localparam int NumPhases      = 8;
  localparam int RandomPerPhase = 141;
  localparam int DrainCycles    = 16;      // pipeline is two deep, leave slack
  localparam int CycleLimit     = 200000;

  // poc types beyond the two the package names
  localparam logic [PocTypeW-1:0] PocType2 = 2'd2;
  localparam logic [PocTypeW-1:0] PocType3 = 2'd3;

  // Register settings, one per phase: {poc_type, delta_poc_always_zero,
  // bottom_poc_present}. Covers both flag values under each compared poc
  // type plus the types that compare no poc field at all.
  localparam cfg_t PhaseCfg [NumPhases] = '{
    '{PocType0, 1'b0, 1'b1},
    '{PocType0, 1'b1, 1'b0},
    '{PocType1, 1'b0, 1'b1},
    '{PocType1, 1'b0, 1'b0},
    '{PocType1, 1'b1, 1'b1},
    '{PocType2, 1'b0, 1'b1},
    '{PocType3, 1'b1, 1'b1},
    '{PocType0, 1'b0, 1'b0}
  };

  // receiver stall behavior, re-picked at random whenever a mode's stretch runs out
  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // pps_id, frame_number, field_pic, bottom_flag,
                                        // idr_id, poc_lsb, delta_poc_bottom,
                                        // delta_poc_first, delta_poc_second, pad
  logic [InTuserW-1:0]  s_axis_tuser;   // is_idr, slice_kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;   // new_picture, pad
  logic [OutTuserW-1:0] m_axis_tuser;   // frame_type, picture_structure
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int     errors;
  int     pending;
  int     checked;
  int     new_pics;
  int     cycle_count = 0;
  int     burst_left  = 0;
  int     headers_sent = 0;
  int     stall_left  = 0;
  stall_e stall_mode  = StallNone;
  cfg_t   run_cfg;
  slice_t last_hdr;

  h264_new_picture_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  npd_result_checker result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_valid_i (s_axis_tvalid),
    .hdr_ready_i (s_axis_tready),
    .hdr_tdata_i (s_axis_tdata),
    .hdr_tuser_i (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_tdata_i (m_axis_tdata),
    .res_tuser_i (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .new_pics_o  (new_pics)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("h264_new_picture_detector test failed");
      $finish;
    end
  end

  // Result side backpressure. Each mode holds for a random stretch, so long
  // stretches of full throughput alternate with light, heavy and periodic stalls.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 200);
    end
    stall_left--;
    case (stall_mode)
      StallNone:  m_axis_tready = 1'b1;
      StallLight: m_axis_tready = ($urandom_range(0, 9) < 7);
      StallHeavy: m_axis_tready = ($urandom_range(0, 9) < 3);
      default:    m_axis_tready = ((stall_left % 12) < 5);
    endcase
  end

  // Half the time a value of the field's full range, otherwise an edge value.
  function automatic logic [31:0] pick_word(input int unsigned w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return mask;
      2:       return 32'd1 << (w - 1);
      3:       return (32'd1 << (w - 1)) - 1;
      default: return $urandom & mask;
    endcase
  endfunction

  // XOR mask: a single bit half the time, otherwise a picked word.
  function automatic logic [31:0] flip_mask(input int unsigned w);
    if ($urandom_range(0, 1)) return 32'd1 << $urandom_range(0, w - 1);
    return pick_word(w);
  endfunction

  function automatic slice_t random_header();
    slice_t h;
    h.pps_id           = PpsIdW'(pick_word(PpsIdW));
    h.frame_number     = FrameNumW'(pick_word(FrameNumW));
    h.field_pic        = 1'($urandom_range(0, 1));
    h.bottom_flag      = 1'($urandom_range(0, 1));
    h.is_idr           = 1'($urandom_range(0, 1));
    h.idr_id           = IdrIdW'(pick_word(IdrIdW));
    h.poc_lsb          = PocLsbW'(pick_word(PocLsbW));
    h.delta_poc_bottom = pick_word(DeltaW);
    h.delta_poc_first  = pick_word(DeltaW);
    h.delta_poc_second = pick_word(DeltaW);
    h.slice_kind       = KindW'($urandom_range(0, 7));
    return h;
  endfunction

  // Changes one header field, which usually starts a new picture.
  function automatic slice_t vary_header(input slice_t h);
    slice_t v;
    v = h;
    v.slice_kind = KindW'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: v.pps_id           ^= PpsIdW'(flip_mask(PpsIdW));
      1: v.frame_number     ^= FrameNumW'(flip_mask(FrameNumW));
      2: v.field_pic        = ~v.field_pic;
      3: v.bottom_flag      = ~v.bottom_flag;  // second field of a pair
      4: v.is_idr           = ~v.is_idr;
      5: v.idr_id           ^= IdrIdW'(flip_mask(IdrIdW));
      6: v.poc_lsb          ^= PocLsbW'(flip_mask(PocLsbW));
      7: v.delta_poc_bottom ^= flip_mask(DeltaW);
      8: v.delta_poc_first  ^= flip_mask(DeltaW);
      default: v.delta_poc_second ^= flip_mask(DeltaW);
    endcase
    return v;
  endfunction

  // Next slice of the same picture: compared fields are kept, the fields
  // the current settings leave out get fresh random content.
  function automatic slice_t same_picture(input slice_t h);
    slice_t v;
    logic   bot_delta;
    logic   delta_cmp;
    v = h;
    bot_delta = run_cfg.bottom_poc_present && !h.field_pic;
    delta_cmp = (run_cfg.poc_type == PocType1) && !run_cfg.delta_poc_always_zero;
    v.slice_kind = KindW'($urandom_range(0, 7));
    if (!h.field_pic) v.bottom_flag = 1'($urandom_range(0, 1));
    if (!h.is_idr) v.idr_id = IdrIdW'(pick_word(IdrIdW));
    if (run_cfg.poc_type != PocType0) v.poc_lsb = PocLsbW'(pick_word(PocLsbW));
    if (!((run_cfg.poc_type == PocType0) && bot_delta)) v.delta_poc_bottom = pick_word(DeltaW);
    if (!delta_cmp) v.delta_poc_first = pick_word(DeltaW);
    if (!(delta_cmp && bot_delta)) v.delta_poc_second = pick_word(DeltaW);
    return v;
  endfunction

  // One register write transaction; called only with no header in flight.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(RegPocType, c.poc_type);
    // upper data bit of the flag registers is don't-care, toggle it anyway
    write_reg(RegDeltaZero, {1'($urandom_range(0, 1)), c.delta_poc_always_zero});
    write_reg(RegBotPocPres, {1'($urandom_range(0, 1)), c.bottom_poc_present});
    run_cfg = c;
  endtask

  // Holds the header stream until every result is back.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Header transactions go out in bursts; between bursts tvalid drops for a
  // random gap. Some bursts are long so full-rate stretches occur too.
  task automatic send_header(input slice_t h);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    s_axis_tdata = '0;
    s_axis_tdata[7:0]     = h.pps_id;
    s_axis_tdata[23:8]    = h.frame_number;
    s_axis_tdata[24]      = h.field_pic;
    s_axis_tdata[25]      = h.bottom_flag;
    s_axis_tdata[41:26]   = h.idr_id;
    s_axis_tdata[57:42]   = h.poc_lsb;
    s_axis_tdata[89:58]   = h.delta_poc_bottom;
    s_axis_tdata[121:90]  = h.delta_poc_first;
    s_axis_tdata[153:122] = h.delta_poc_second;
    s_axis_tuser  = {h.slice_kind, h.is_idr};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    headers_sent++;
    last_hdr = h;
  endtask

  // Directed headers under poc type 0 with the bottom poc delta present.
  task automatic run_directed();
    slice_t d;
    d = '0;
    d.is_idr     = 1'b1;
    d.slice_kind = SliceI;
    send_header(d);                      // nothing stored yet: new picture
    send_header(d);                      // identical slice: same picture
    d.bottom_flag = 1'b1;                // frame slice ignores the bottom flag
    send_header(d);
    d.idr_id = '1;                       // both IDR, IDR picture id differs
    send_header(d);
    d.is_idr     = 1'b0;
    d.slice_kind = SliceP;
    send_header(d);
    d.idr_id = 16'h1234;                 // not IDR: IDR picture id ignored
    send_header(d);
    d.pps_id = '1;
    send_header(d);
    d.frame_number = '1;
    send_header(d);
    d.poc_lsb = '1;
    send_header(d);
    d.delta_poc_bottom = 32'h8000_0000;  // most negative delta
    send_header(d);
    d.delta_poc_bottom = 32'h7fff_ffff;  // most positive delta
    send_header(d);
    d.delta_poc_first  = '1;             // type 1 deltas are absent here
    d.delta_poc_second = 32'h8000_0000;
    send_header(d);
    d.field_pic   = 1'b1;                // top field
    d.bottom_flag = 1'b0;
    send_header(d);
    d.bottom_flag = 1'b1;                // bottom field of the pair
    send_header(d);
    d.delta_poc_bottom = '0;             // field slice: bottom delta absent
    send_header(d);
    for (int k = 0; k < 8; k++) begin   // every slice kind incl. the unused ones
      d.slice_kind = KindW'(k);
      send_header(d);
    end
    d.is_idr     = 1'b1;                 // IDR wins over the slice kind
    d.slice_kind = SliceB;
    send_header(d);
  endtask

  initial begin
    int unsigned r;
    slice_t      h;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    run_cfg       = '0;
    last_hdr      = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      apply_config(PhaseCfg[p]);
      if (p == 0) run_directed();
      // Mostly well-formed picture sequences: runs of slices of one picture
      // broken by single-field changes, with some fully random headers.
      for (int i = 0; i < RandomPerPhase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12) h = random_header();
        else if (r < 40) h = vary_header(last_hdr);
        else h = same_picture(last_hdr);
        send_header(h);
        if (i == RandomPerPhase / 2) drain_results();  // full drain mid-phase
      end
      drain_results();
    end
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d slice headers over %0d register settings (poc types 0-3).",
             headers_sent, NumPhases);
    $display("Checked %0d results, %0d of them flagged as a new picture.", checked, new_pics);
    if (errors == 0) begin
      $display("h264_new_picture_detector test passed");
    end else begin
      $display("h264_new_picture_detector test failed");
    end
    $finish;
  end

endmodule
